>>> sv/pst_pkg.sv
// Package for the protocol socket table: beat types, status and function codes,
// sequencer states and the kernel protocols present after reset.
// Has no dependencies; all other files refer to it by scoped names.
package pst_pkg;

   localparam int NUM_SOCKETS_DEFAULT = 16;
   localparam int KERNEL_COUNT = 4;

   localparam logic [15:0] KERNEL_PROTOCOLS [KERNEL_COUNT] = '{
      16'h0001, 16'h0201, 16'h021F, 16'h0230
   };

   localparam logic [7:0] FUNC_OPEN = 8'd1;
   localparam logic [7:0] FUNC_CLOSE = 8'd2;
   localparam logic [7:0] FUNC_SEND = 8'd3;
   localparam logic [7:0] FUNC_SILENT_LO = 8'd4;
   localparam logic [7:0] FUNC_SILENT_HI = 8'd9;

   localparam logic signed [7:0] DEST_H = 8'sh48;
   localparam logic signed [7:0] DEST_I = 8'sh49;

   typedef enum logic [2:0] {
      STATUS_OK = 3'd0,
      STATUS_BAD_CALL = 3'd1,
      STATUS_BAD_SOCKET = 3'd2,
      STATUS_TAKEN = 3'd3,
      STATUS_FULL = 3'd4,
      STATUS_NO_LINK = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_OPEN_END,
      S_LOOKUP,
      S_CHECK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [7:0] func;
      logic [15:0] protocol;
      logic [31:0] option;
      logic [31:0] handler;
      logic [7:0] socket_number;
      logic signed [7:0] destination;
   } req_type;

   typedef struct packed {
      logic answer_written;
      logic [2:0] status;
      logic [4:0] opened_socket;
   } rsp_type;

   typedef struct packed {
      logic occupied;
      logic equal;
   } match_type;

   function automatic logic [15:0] kernel_protocol(input int unsigned idx);
      logic [15:0] value;
      value = 16'h0000;
      if (idx < KERNEL_COUNT) begin
         value = KERNEL_PROTOCOLS[idx[1:0]];
      end
      return value;
   endfunction

endpackage

>>> sv/pst_match.sv
// Shared compare unit of the socket table: checks one table entry against the
// requested protocol. Depends on pst_pkg for the match result type.
module pst_match (
   input logic [15:0] entry,
   input logic [15:0] key,
   output pst_pkg::match_type match
);

   always_comb begin
      match.occupied = (entry != 16'h0000);
      match.equal = (entry == key);
   end

endmodule

>>> sv/pst_proto_mem.sv
// Protocol memory of the socket table with one registered read port and one
// write port; per-entry valid bits supply the reset contents. Depends on pst_pkg.
module pst_proto_mem #(
   parameter int NUM_SOCKETS = pst_pkg::NUM_SOCKETS_DEFAULT,
   parameter int IDX_W = $clog2(NUM_SOCKETS)
) (
   input logic clock,
   input logic reset,
   input logic rd_en,
   input logic [IDX_W-1:0] rd_addr,
   output logic [15:0] rd_data,
   input logic wr_en,
   input logic [IDX_W-1:0] wr_addr,
   input logic [15:0] wr_data
);

   logic [15:0] mem [NUM_SOCKETS];
   logic [NUM_SOCKETS-1:0] valid_ff;
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (valid_ff[rd_addr]) begin
            rd_data_ff <= mem[rd_addr];
         end else begin
            rd_data_ff <= pst_pkg::kernel_protocol(32'(rd_addr));
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/pst_payload_mem.sv
// Option and handler memory of the socket table, written when a socket opens.
// Depends on pst_pkg only through the parameter default.
module pst_payload_mem #(
   parameter int NUM_SOCKETS = pst_pkg::NUM_SOCKETS_DEFAULT,
   parameter int IDX_W = $clog2(NUM_SOCKETS)
) (
   input logic clock,
   input logic wr_en,
   input logic [IDX_W-1:0] wr_addr,
   input logic [31:0] wr_option,
   input logic [31:0] wr_handler
);

   logic [63:0] mem [NUM_SOCKETS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_option, wr_handler};
      end
   end

endmodule

>>> sv/protocol_socket_table.sv
// Top level of the protocol socket table: request sequencer, shared compare
// unit and the protocol and payload memories. Depends on pst_pkg and all pst_ modules.
//
// A request beat is taken when start is high and busy is low; every request
// produces exactly one response beat, shown on rsp_data for the single cycle in
// which rsp_strobe is high, and the receiver cannot stall it. An open walks the
// whole table through the one compare unit, one socket per cycle, and its response
// beat follows the scan, scan-end and open-end states; the next request can be
// taken in the cycle after the response beat. A close or send request for a socket
// number in range reads one entry in the lookup state and answers from the check
// state; all other requests, including those for a socket number out of range,
// answer straight from the idle state. There is no clearing pass after reset; the
// kernel protocols are present at once.
module protocol_socket_table #(
   parameter int NUM_SOCKETS = pst_pkg::NUM_SOCKETS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic start,
   input pst_pkg::req_type req_data,
   output logic busy,
   output logic rsp_strobe,
   output pst_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(NUM_SOCKETS);
   localparam int SOCK_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOCKETS - 1);

   pst_pkg::state_type state_ff, state_in;
   pst_pkg::req_type req_ff;
   pst_pkg::rsp_type rsp_ff, rsp_in;
   pst_pkg::match_type match;
   logic rsp_load;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic chk_valid_ff;
   logic [IDX_W-1:0] chk_idx_ff;
   logic present_ff;
   logic free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic accept;
   logic sock_in_range;
   logic [IDX_W-1:0] sock_idx;
   logic rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [15:0] rd_data;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [15:0] wr_data;
   logic pay_wr_en;

   assign accept = start && (state_ff == pst_pkg::S_IDLE);
   assign busy = (state_ff != pst_pkg::S_IDLE);
   assign rsp_strobe = (state_ff == pst_pkg::S_DONE);
   assign rsp_data = rsp_ff;
   assign sock_in_range = (req_data.socket_number != 8'd0)
      && (req_data.socket_number <= 8'(NUM_SOCKETS));
   assign sock_idx = IDX_W'(req_ff.socket_number - 8'd1);

   pst_match u_match (
      .entry(rd_data),
      .key(req_ff.protocol),
      .match(match)
   );

   pst_proto_mem #(
      .NUM_SOCKETS(NUM_SOCKETS),
      .IDX_W(IDX_W)
   ) u_proto_mem (
      .clock(clock),
      .reset(reset),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   pst_payload_mem #(
      .NUM_SOCKETS(NUM_SOCKETS),
      .IDX_W(IDX_W)
   ) u_payload_mem (
      .clock(clock),
      .wr_en(pay_wr_en),
      .wr_addr(free_idx_ff),
      .wr_option(req_ff.option),
      .wr_handler(req_ff.handler)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pst_pkg::S_IDLE: begin
            if (start) begin
               unique case (req_data.func) inside
                  pst_pkg::FUNC_OPEN: state_in = pst_pkg::S_SCAN;
                  pst_pkg::FUNC_CLOSE, pst_pkg::FUNC_SEND: begin
                     state_in = sock_in_range ? pst_pkg::S_LOOKUP : pst_pkg::S_DONE;
                  end
                  default: state_in = pst_pkg::S_DONE;
               endcase
            end
         end
         pst_pkg::S_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = pst_pkg::S_SCAN_END;
            end
         end
         pst_pkg::S_SCAN_END: state_in = pst_pkg::S_OPEN_END;
         pst_pkg::S_OPEN_END: state_in = pst_pkg::S_DONE;
         pst_pkg::S_LOOKUP: state_in = pst_pkg::S_CHECK;
         pst_pkg::S_CHECK: state_in = pst_pkg::S_DONE;
         pst_pkg::S_DONE: state_in = pst_pkg::S_IDLE;
         default: state_in = pst_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      rd_en = 1'b0;
      rd_addr = idx_ff;
      wr_en = 1'b0;
      wr_addr = free_idx_ff;
      wr_data = req_ff.protocol;
      pay_wr_en = 1'b0;
      rsp_load = 1'b0;
      rsp_in = '0;
      idx_in = idx_ff;
      unique case (state_ff)
         pst_pkg::S_IDLE: begin
            idx_in = '0;
            if (start) begin
               rsp_load = 1'b1;
               rsp_in.answer_written = 1'b1;
               unique case (req_data.func) inside
                  pst_pkg::FUNC_OPEN, pst_pkg::FUNC_CLOSE, pst_pkg::FUNC_SEND: begin
                     rsp_in.status = pst_pkg::STATUS_BAD_SOCKET;
                  end
                  [pst_pkg::FUNC_SILENT_LO:pst_pkg::FUNC_SILENT_HI]: begin
                     rsp_in.answer_written = 1'b0;
                     rsp_in.status = pst_pkg::STATUS_OK;
                  end
                  default: rsp_in.status = pst_pkg::STATUS_BAD_CALL;
               endcase
            end
         end
         pst_pkg::S_SCAN: begin
            rd_en = 1'b1;
            rd_addr = idx_ff;
            idx_in = idx_ff + 1'b1;
         end
         pst_pkg::S_OPEN_END: begin
            rsp_load = 1'b1;
            rsp_in.answer_written = 1'b1;
            if (present_ff) begin
               rsp_in.status = pst_pkg::STATUS_TAKEN;
            end else if (free_found_ff) begin
               rsp_in.status = pst_pkg::STATUS_OK;
               rsp_in.opened_socket = 5'(SOCK_W'(free_idx_ff) + SOCK_W'(1));
               wr_en = 1'b1;
               pay_wr_en = 1'b1;
            end else begin
               rsp_in.status = pst_pkg::STATUS_FULL;
            end
         end
         pst_pkg::S_LOOKUP: begin
            rd_en = 1'b1;
            rd_addr = sock_idx;
         end
         pst_pkg::S_CHECK: begin
            rsp_load = 1'b1;
            rsp_in.answer_written = 1'b1;
            if (!match.occupied) begin
               rsp_in.status = pst_pkg::STATUS_BAD_SOCKET;
            end else if (req_ff.func == pst_pkg::FUNC_CLOSE) begin
               rsp_in.status = pst_pkg::STATUS_OK;
               wr_en = 1'b1;
               wr_addr = sock_idx;
               wr_data = 16'h0000;
            end else if ((req_ff.destination == pst_pkg::DEST_H)
                  || (req_ff.destination == pst_pkg::DEST_I)) begin
               rsp_in.status = pst_pkg::STATUS_NO_LINK;
            end else begin
               rsp_in.status = pst_pkg::STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pst_pkg::S_IDLE;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chk_valid_ff <= (state_ff == pst_pkg::S_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      chk_idx_ff <= idx_ff;
      if (accept) begin
         req_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         present_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (chk_valid_ff) begin
         if (match.occupied && match.equal) begin
            present_ff <= 1'b1;
         end
         if (!match.occupied && (chk_idx_ff != '0) && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff <= chk_idx_ff;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("Response strobe lasted more than one cycle.");

   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("Block not busy after taking a request.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.opened_socket != 5'd0))
      |-> (rsp_data.answer_written && (rsp_data.status == pst_pkg::STATUS_OK)))
      else $error("Opened socket reported without a successful answer.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.answer_written)
      |-> (rsp_data.status == pst_pkg::STATUS_OK))
      else $error("Silent response carries a status.");

endmodule
